@@ hw/rtl/wca_pkg.sv @@
`timescale 1ns / 1ps

package wca_pkg;

  // Widths fixed by the stream fields
  localparam int ACC_W  = 32;
  localparam int COST_W = 16;
  localparam int STEP_W = 3;
  localparam int WC_W   = 21;   // rounded weight * local cost

  localparam logic [ACC_W-1:0] ACC_ALL_ONES = {ACC_W{1'b1}};

  // Step slots held by the offset and weight registers
  localparam int REG_STEP_SLOTS = 4;

  // Parameter defaults
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_STEPS  = 4;
  localparam int DEF_MAX_OFFSET = 3;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_STEPS     = 3'd0;
  localparam logic [2:0] CFG_STEP_OFFSETS  = 3'd1;
  localparam logic [2:0] CFG_STEP_WEIGHTS  = 3'd2;
  localparam logic [2:0] CFG_WINDOW_ENABLE = 3'd3;
  localparam logic [2:0] CFG_WINDOW_SIZE   = 3'd4;
  localparam logic [2:0] CFG_ROW_COUNT     = 3'd5;
  localparam logic [2:0] CFG_COL_COUNT     = 3'd6;

  // Configuration reset values
  localparam logic [2:0]  RST_NUM_STEPS     = 3'd3;
  localparam logic [15:0] RST_STEP_OFFSETS  = 16'd1045;
  localparam logic [63:0] RST_STEP_WEIGHTS  = 64'd17592454483968;
  localparam logic        RST_WINDOW_ENABLE = 1'b0;
  localparam logic [10:0] RST_WINDOW_SIZE   = 11'd1024;
  localparam logic [10:0] RST_ROW_COUNT     = 11'd1024;
  localparam logic [10:0] RST_COL_COUNT     = 11'd1024;

endpackage

@@ hw/rtl/dtw_windowed_cost_accumulator.sv @@
`timescale 1ns / 1ps

// Windowed accumulated-cost engine (banded time-warping recurrence).
// Channels:
//   s_*   : one local cost per transaction, cells in column-major order.
//   m_*   : one result per cell: accumulated cost, winning step, tlast on the
//           final cell of the matrix.
//   cfg_* : register writes (index, data); always ready. Write only while idle.
// Slots: each cell is evaluated in min(MAX_STEPS, 4) step slots (4 at default). Each step
//   slot takes one predecessor read from the single read port of the history
//   RAM; the next cell's slots start as soon as the last slot is issued.
// Reset: registers return to defaults, position to cell (0,0). The history RAM
//   is not cleared; each entry is written before it is read in normal use.
// Stall: a finished result waits in the output register while the next cell is
//   accepted and evaluated; the engine freezes only when a second result is
//   complete and the first has still not been taken.
module dtw_windowed_cost_accumulator
  import wca_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_STEPS  = DEF_MAX_STEPS,
  parameter int MAX_OFFSET = DEF_MAX_OFFSET
) (
  input  logic        clk,
  input  logic        rst,
  // input cells
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // [15:0] local_cost
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // [31:0] acc_cost, [34:32] step_taken, rest 0
  output logic        m_tlast,     // last_cell
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int HIST  = MAX_OFFSET + 1;
  localparam int NSLOT = (MAX_STEPS < REG_STEP_SLOTS) ? MAX_STEPS : REG_STEP_SLOTS;
  localparam int KW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int MW    = (RW > CW) ? RW : CW;
  localparam int SW    = (MW + 1 > 11) ? MW + 1 : 11;   // matrix sizes
  localparam int DW    = (MW + 2 > 12) ? MW + 2 : 12;   // distances, band
  localparam int SLW   = $clog2(HIST);
  localparam int AW    = $clog2(HIST * MAX_ROWS);
  localparam int TW    = $clog2(3 * HIST) + 1;
  localparam int DEPTH = HIST * MAX_ROWS;

  localparam logic [KW-1:0] K_LAST = KW'(NSLOT - 1);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [RW-1:0]     row;
    logic [CW-1:0]     col;
    logic [SLW-1:0]    slot;     // column mod history depth
    logic              origin;
    logic              outside;  // outside the band
    logic              last;
  } cell_t;

  // ---------------- configuration ----------------
  logic [2:0]  num_steps;
  logic [15:0] step_offsets;
  logic [63:0] step_weights;
  logic        window_enable;
  logic [10:0] window_size;
  logic [10:0] row_count;
  logic [10:0] col_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps     <= RST_NUM_STEPS;
      step_offsets  <= RST_STEP_OFFSETS;
      step_weights  <= RST_STEP_WEIGHTS;
      window_enable <= RST_WINDOW_ENABLE;
      window_size   <= RST_WINDOW_SIZE;
      row_count     <= RST_ROW_COUNT;
      col_count     <= RST_COL_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_STEPS:     num_steps     <= cfg_data[2:0];
        CFG_STEP_OFFSETS:  step_offsets  <= cfg_data[15:0];
        CFG_STEP_WEIGHTS:  step_weights  <= cfg_data;
        CFG_WINDOW_ENABLE: window_enable <= cfg_data[0];
        CFG_WINDOW_SIZE:   window_size   <= cfg_data[10:0];
        CFG_ROW_COUNT:     row_count     <= cfg_data[10:0];
        CFG_COL_COUNT:     col_count     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Derived from configuration: clamped sizes, band, step count
  logic [SW-1:0] rows_c, cols_c;
  logic [DW-1:0] band;
  logic [2:0]    n_use;

  always_comb begin
    if (row_count == 11'd0)                    rows_c = SW'(1);
    else if (SW'(row_count) > SW'(MAX_ROWS))   rows_c = SW'(MAX_ROWS);
    else                                       rows_c = SW'(row_count);
    if (col_count == 11'd0)                    cols_c = SW'(1);
    else if (SW'(col_count) > SW'(MAX_COLS))   cols_c = SW'(MAX_COLS);
    else                                       cols_c = SW'(col_count);
    if (window_enable)        band = DW'(window_size);
    else if (rows_c > cols_c) band = DW'(rows_c) + DW'(1);
    else                      band = DW'(cols_c) + DW'(1);
    n_use = (num_steps > 3'(NSLOT)) ? 3'(NSLOT) : num_steps;
  end

  // ---------------- position and acceptance ----------------
  logic [RW-1:0]  row_pos;
  logic [CW-1:0]  col_pos;
  logic [SLW-1:0] col_slot;

  logic          cur_valid;
  logic [KW-1:0] kq;
  cell_t         cur;

  logic          p_valid;
  logic [KW-1:0] p_k;
  logic          p_qual;
  logic [WC_W-1:0] p_wc;
  cell_t         p_cell;

  logic advance, accept, p_fin, wen;

  assign p_fin    = p_valid && (p_k == K_LAST);
  assign advance  = !(p_fin && m_tvalid && !m_tready);
  assign s_tready = advance && (!cur_valid || kq == K_LAST);
  assign accept   = s_tvalid && s_tready;

  logic          wrap_row, wrap_col, at_last;
  logic [DW-1:0] pos_dist;
  cell_t         new_cell;

  always_comb begin
    wrap_row = (SW'(row_pos) + SW'(1)) >= rows_c;
    wrap_col = (SW'(col_pos) + SW'(1)) >= cols_c;
    at_last  = wrap_row && wrap_col;
    pos_dist = (DW'(row_pos) >= DW'(col_pos)) ? DW'(row_pos) - DW'(col_pos)
                                               : DW'(col_pos) - DW'(row_pos);
    new_cell.cost    = s_tdata[COST_W-1:0];
    new_cell.row     = row_pos;
    new_cell.col     = col_pos;
    new_cell.slot    = col_slot;
    new_cell.origin  = (row_pos == '0) && (col_pos == '0);
    new_cell.outside = window_enable && (pos_dist > band);
    new_cell.last    = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      col_slot <= '0;
    end else if (accept) begin
      if (at_last) begin
        row_pos  <= '0;
        col_pos  <= '0;
        col_slot <= '0;
      end else if (wrap_row) begin
        row_pos  <= '0;
        col_pos  <= col_pos + CW'(1);
        col_slot <= (col_slot == SLW'(HIST - 1)) ? '0 : col_slot + SLW'(1);
      end else begin
        row_pos <= row_pos + RW'(1);
      end
    end
  end

  // ---------------- step slot issue ----------------
  logic [1:0]      ro, co;
  logic [15:0]     w;
  logic [DW-1:0]   pi, pj, pdist;
  logic            qual;
  logic [31:0]     prod;
  logic [WC_W-1:0] wc;
  logic [TW-1:0]   t0, t1, t2;
  logic [SLW-1:0]  pslot;
  logic [AW-1:0]   raddr, waddr;

  always_comb begin
    ro    = step_offsets[4*kq +: 2];
    co    = step_offsets[4*kq + 2 +: 2];
    w     = step_weights[16*kq +: 16];
    pi    = DW'(cur.row) - DW'(ro);
    pj    = DW'(cur.col) - DW'(co);
    pdist = (pi >= pj) ? pi - pj : pj - pi;
    qual  = (3'(kq) < n_use) && (ro != 2'd0 || co != 2'd0) &&
            (DW'(cur.row) >= DW'(ro)) && (DW'(cur.col) >= DW'(co)) &&
            (pdist <= band);
    prod  = 32'(w) * 32'(cur.cost);
    wc    = WC_W'((33'(prod) + 33'd2048) >> 12);
    // predecessor column slot: (slot - co) mod HIST
    t0    = TW'(cur.slot) + TW'(2 * HIST) - TW'(co);
    t1    = (t0 >= TW'(HIST)) ? t0 - TW'(HIST) : t0;
    t2    = (t1 >= TW'(HIST)) ? t1 - TW'(HIST) : t1;
    pslot = SLW'(t2);
    raddr = AW'(pslot) * AW'(MAX_ROWS) + AW'(RW'(pi));
    waddr = AW'(p_cell.slot) * AW'(MAX_ROWS) + AW'(p_cell.row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      kq        <= '0;
      p_valid   <= 1'b0;
    end else if (advance) begin
      p_valid <= cur_valid;
      if (!cur_valid || kq == K_LAST) begin
        cur_valid <= accept;
        kq        <= '0;
      end else begin
        kq <= kq + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (accept) cur <= new_cell;
      p_k    <= kq;
      p_qual <= qual;
      p_wc   <= wc;
      p_cell <= cur;
    end
  end

  // ---------------- history RAM ----------------
  logic [ACC_W-1:0] hist;
  logic [ACC_W-1:0] fin_acc;

  wca_history #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_history (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (raddr),
    .rd_data (hist),
    .wr_en   (wen),
    .wr_addr (waddr),
    .wr_data (fin_acc)
  );

  // ---------------- compare and accumulate ----------------
  logic [ACC_W-1:0]  best, base_best, best_next, cand;
  logic [STEP_W-1:0] win, base_win, win_next, fin_step;
  logic [STEP_W-1:0] last_step;
  logic [ACC_W:0]    sum;
  logic              take;

  always_comb begin
    if (p_k == '0) begin
      base_best = p_cell.origin ? ACC_W'(p_cell.cost) : ACC_ALL_ONES;
      base_win  = '0;
    end else begin
      base_best = best;
      base_win  = win;
    end
    sum       = (ACC_W+1)'(p_wc) + (ACC_W+1)'(hist);
    cand      = sum[ACC_W] ? ACC_ALL_ONES : sum[ACC_W-1:0];
    take      = p_qual && (cand < base_best);
    best_next = take ? cand : base_best;
    win_next  = take ? STEP_W'(p_k) + STEP_W'(1) : base_win;
    if (p_cell.outside) begin
      fin_acc  = '0;
      fin_step = '0;
    end else begin
      fin_acc = best_next;
      if (win_next != '0)     fin_step = win_next;
      else if (p_cell.origin) fin_step = '0;
      else                    fin_step = last_step;
    end
  end

  assign wen = advance && p_fin;

  always_ff @(posedge clk) begin
    if (advance && p_valid) begin
      best <= best_next;
      win  <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_step <= '0;
    end else if (wen && !p_cell.outside) begin
      last_step <= fin_step;
    end
  end

  // ---------------- output register ----------------
  logic [ACC_W-1:0]  acc_q;
  logic [STEP_W-1:0] step_q;
  logic              last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wen) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      acc_q  <= fin_acc;
      step_q <= fin_step;
      last_q <= p_cell.last;
    end
  end

  assign m_tdata = {5'd0, step_q, acc_q};
  assign m_tlast = last_q;

  // ---------------- assertions ----------------
  a_accept_starts_slot0 : assert property (@(posedge clk) disable iff (rst)
    accept |=> (cur_valid && kq == '0))
    else $error("accepted cell did not start at slot 0");

  a_idle_slot_zero : assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> (kq == '0))
    else $error("slot counter running without a cell");

  a_slot_order : assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_k != '0) |-> $past(p_valid))
    else $error("accumulate slot without preceding slot");

  a_step_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (step_q <= STEP_W'(NSLOT)))
    else $error("winning step index out of range");

endmodule

@@ hw/rtl/wca_history.sv @@
`timescale 1ns / 1ps

// Accumulated-cost history: 1W1R synchronous RAM, registered read,
// with forwarding of the latest write (covers write and read on the same edge).
module wca_history
  import wca_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ACC_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ACC_W-1:0] wr_data
);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [ACC_W-1:0] mem_q;
  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    lw_addr;
  logic [ACC_W-1:0] lw_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      lw_addr      <= wr_addr;
      lw_data      <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign rd_data = (rd_addr_q == lw_addr) ? lw_data : mem_q;

endmodule

@@ tb/sv/dtw_windowed_cost_accumulator_tb.sv @@
`timescale 1ns / 1ps

module dtw_windowed_cost_accumulator_tb;
  import wca_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HIST_COLS   = DEF_MAX_OFFSET + 1;
  localparam int RAND_CELLS  = 360;
  // index 7 maps to no register; a write there must change nothing
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef enum logic { ITEM_CELL, ITEM_REG } item_kind_t;

  typedef struct {
    item_kind_t  kind;
    logic [2:0]  idx;
    logic [63:0] data;
    int unsigned idle_pct;   // chance of a burst of idle cycles, both sides
  } stim_item_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  step;
    logic        last;
  } cell_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  dtw_windowed_cost_accumulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  stim_item_t   pending_q[$];
  cell_result_t expect_q[$];

  int unsigned in_gap, out_stall;
  int unsigned ready_pct = 0;
  int unsigned err_cnt = 0, cells_sent = 0, regs_written = 0, results_seen = 0;
  int unsigned cycle_cnt = 0;

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers, cost history and matrix position
  // ---------------------------------------------------------------------------
  logic [2:0]  sh_num_steps;
  logic [15:0] sh_offsets;
  logic [63:0] sh_weights;
  logic        sh_win_en;
  logic [10:0] sh_win_size;
  logic [10:0] sh_row_count;
  logic [10:0] sh_col_count;
  logic [31:0] acc_hist [0:HIST_COLS*DEF_MAX_ROWS-1];
  logic [2:0]  sh_last_step;
  int unsigned sh_row, sh_col;

  task automatic reset_shadow();
    sh_num_steps = RST_NUM_STEPS;
    sh_offsets   = RST_STEP_OFFSETS;
    sh_weights   = RST_STEP_WEIGHTS;
    sh_win_en    = RST_WINDOW_ENABLE;
    sh_win_size  = RST_WINDOW_SIZE;
    sh_row_count = RST_ROW_COUNT;
    sh_col_count = RST_COL_COUNT;
    sh_last_step = '0;
    sh_row = 0;
    sh_col = 0;
    for (int a = 0; a < HIST_COLS*DEF_MAX_ROWS; a++) acc_hist[a] = '0;
  endtask

  task automatic write_shadow(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      CFG_NUM_STEPS:     sh_num_steps = d[2:0];
      CFG_STEP_OFFSETS:  sh_offsets   = d[15:0];
      CFG_STEP_WEIGHTS:  sh_weights   = d;
      CFG_WINDOW_ENABLE: sh_win_en    = d[0];
      CFG_WINDOW_SIZE:   sh_win_size  = d[10:0];
      CFG_ROW_COUNT:     sh_row_count = d[10:0];
      CFG_COL_COUNT:     sh_col_count = d[10:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    int unsigned vv;
    vv = 32'(v);
    if (vv == 0) return 1;
    if (vv > hi) return hi;
    return vv;
  endfunction

  // Accumulated cost of the next cell in column-major order; updates history
  // and position.
  function automatic cell_result_t next_cell_result(input logic [15:0] cost);
    cell_result_t r;
    int unsigned  rows, cols, n, i, j, ro, co, pi, pj;
    longint       band, gap;
    logic [63:0]  w, cand;
    logic [31:0]  best;
    rows = clamp_dim(sh_row_count, DEF_MAX_ROWS);
    cols = clamp_dim(sh_col_count, DEF_MAX_COLS);
    i = sh_row;
    j = sh_col;
    r.last = (i + 1 >= rows) && (j + 1 >= cols);
    band = sh_win_en ? longint'(sh_win_size) : longint'((rows > cols ? rows : cols) + 1);
    gap = longint'(i) - longint'(j);
    if (gap < 0) gap = -gap;
    if (sh_win_en && gap > band) begin
      // outside the band: zero cost, history gets zero, last step untouched
      r.acc  = '0;
      r.step = '0;
    end else begin
      n = 32'(sh_num_steps);
      if (n > DEF_MAX_STEPS) n = DEF_MAX_STEPS;
      if (n > REG_STEP_SLOTS) n = REG_STEP_SLOTS;
      if (i == 0 && j == 0) begin
        best = {16'd0, cost};
        sh_last_step = '0;
      end else begin
        best = ACC_ALL_ONES;
      end
      for (int k = 0; k < int'(n); k++) begin
        ro = 32'(sh_offsets[4*k +: 2]);
        co = 32'(sh_offsets[4*k+2 +: 2]);
        w  = {48'd0, sh_weights[16*k +: 16]};
        if (ro == 0 && co == 0) continue;
        if (i < ro || j < co) continue;
        pi = i - ro;
        pj = j - co;
        gap = longint'(pi) - longint'(pj);
        if (gap < 0) gap = -gap;
        if (gap > band) continue;
        cand = ((w * {48'd0, cost} + 64'd2048) >> 12)
               + {32'd0, acc_hist[(pj % HIST_COLS) * DEF_MAX_ROWS + pi]};
        if (cand > {32'd0, ACC_ALL_ONES}) cand = {32'd0, ACC_ALL_ONES};
        if (cand < {32'd0, best}) begin
          best = cand[31:0];
          sh_last_step = 3'(k + 1);
        end
      end
      r.acc  = best;
      r.step = sh_last_step;
    end
    acc_hist[(j % HIST_COLS) * DEF_MAX_ROWS + i] = r.acc;
    if (r.last) begin
      sh_row = 0;
      sh_col = 0;
    end else if (i + 1 >= rows) begin
      sh_row = 0;
      sh_col = j + 1;
    end else begin
      sh_row = i + 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transaction at a time from pending_q; register writes wait
  // until every outstanding cell result has been taken (block idle).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
      in_gap = 0;
      reset_shadow();
    end else begin
      if (cfg_valid && cfg_ready) begin
        write_shadow(cfg_index, cfg_data);
        regs_written++;
      end
      if (s_tvalid && s_tready) begin
        expect_q.push_back(next_cell_result(s_tdata));
        cells_sent++;
      end
      // an offered transaction stays put until taken
      if (!(s_tvalid && !s_tready) && !(cfg_valid && !cfg_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid  <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          s_tvalid  <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (pending_q[0].kind == ITEM_REG) begin
          s_tvalid <= 1'b0;
          if (expect_q.size() == 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= pending_q[0].idx;
            cfg_data  <= pending_q[0].data;
            ready_pct <= pending_q[0].idle_pct;
            pending_q.delete(0);
          end else begin
            cfg_valid <= 1'b0;
          end
        end else begin
          cfg_valid <= 1'b0;
          if (pending_q[0].idle_pct != 0 && $urandom_range(99) < pending_q[0].idle_pct) begin
            in_gap = $urandom_range(19, 1) - 1;
            s_tvalid <= 1'b0;
          end else begin
            s_tvalid  <= 1'b1;
            s_tdata   <= pending_q[0].data[15:0];
            ready_pct <= pending_q[0].idle_pct;
            pending_q.delete(0);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result transaction with the oldest prediction and
  // throttles m_tready in random bursts.
  // ---------------------------------------------------------------------------
  task automatic score_result();
    cell_result_t want;
    results_seen++;
    if (expect_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result %0d: acc %h step %0d last %0b", results_seen,
                 m_tdata[31:0], m_tdata[34:32], m_tlast);
    end else begin
      want = expect_q.pop_front();
      if (m_tdata[31:0] !== want.acc || m_tdata[34:32] !== want.step ||
          m_tdata[39:35] !== 5'd0 || m_tlast !== want.last) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("result %0d mismatch (exp/act): acc %h/%h step %0d/%0d last %0b/%0b pad %h",
                   results_seen, want.acc, m_tdata[31:0], want.step, m_tdata[34:32],
                   want.last, m_tlast, m_tdata[39:35]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_tvalid && m_tready) score_result();
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else if (ready_pct != 0 && $urandom_range(99) < ready_pct) begin
        out_stall = $urandom_range(19, 1) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[dtw_windowed_cost_accumulator] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned fill_pct = 0;
  int unsigned gen_rows = 32'(RST_ROW_COUNT), gen_cols = 32'(RST_COL_COUNT);

  task automatic queue_reg(input logic [2:0] idx, input logic [63:0] d);
    stim_item_t it;
    it.kind = ITEM_REG;
    it.idx = idx;
    it.data = d;
    it.idle_pct = fill_pct;
    pending_q.push_back(it);
    // track the matrix size so that whole matrices are generated
    if (idx == CFG_ROW_COUNT) gen_rows = clamp_dim(d[10:0], DEF_MAX_ROWS);
    if (idx == CFG_COL_COUNT) gen_cols = clamp_dim(d[10:0], DEF_MAX_COLS);
  endtask

  task automatic queue_cell(input logic [15:0] cost);
    stim_item_t it;
    it.kind = ITEM_CELL;
    it.idx = '0;
    it.data = {48'd0, cost};
    it.idle_pct = fill_pct;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // narrow registers ignore the upper data bits; fill them half of the time
  function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(1)) return v;
    return (junk << w) | v;
  endfunction

  function automatic logic [10:0] pick_dim();
    case ($urandom_range(9))
      0: return 11'd0;     // clamps to 1
      1: return 11'd1;
      default: return 11'($urandom_range(8, 2));
    endcase
  endfunction

  task automatic queue_matrix(inout int unsigned cnt);
    repeat (gen_rows * gen_cols) queue_cell(pick_cost());
    cnt += gen_rows * gen_cols;
  endtask

  task automatic queue_random_setting();
    logic [63:0] wts;
    logic [2:0]  ns;
    logic [10:0] ws;
    if ($urandom_range(3) != 0) begin
      ns = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
      queue_reg(CFG_NUM_STEPS, with_junk({61'd0, ns}, 3));
    end
    if ($urandom_range(1)) queue_reg(CFG_STEP_OFFSETS, with_junk({48'd0, 16'($urandom)}, 16));
    if ($urandom_range(1)) begin
      for (int k = 0; k < REG_STEP_SLOTS; k++)
        case ($urandom_range(5))
          0: wts[16*k +: 16] = 16'h0000;
          1: wts[16*k +: 16] = 16'hFFFF;
          2: wts[16*k +: 16] = 16'h1000;   // 1.0
          3: wts[16*k +: 16] = 16'h0800;   // 0.5, exercises rounding
          default: wts[16*k +: 16] = 16'($urandom);
        endcase
      queue_reg(CFG_STEP_WEIGHTS, wts);
    end
    if ($urandom_range(1)) queue_reg(CFG_WINDOW_ENABLE, with_junk({63'd0, 1'($urandom)}, 1));
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: ws = 11'd0;
        1: ws = 11'd1;
        2: ws = 11'd2047;
        3: ws = 11'd1024;
        default: ws = 11'($urandom_range(6));
      endcase
      queue_reg(CFG_WINDOW_SIZE, with_junk({53'd0, ws}, 11));
    end
    if ($urandom_range(7) == 0) queue_reg(CFG_UNUSED, {$urandom, $urandom});
    queue_reg(CFG_ROW_COUNT, with_junk({53'd0, pick_dim()}, 11));
    queue_reg(CFG_COL_COUNT, with_junk({53'd0, pick_dim()}, 11));
  endtask

  initial begin
    int unsigned rand_cells, phases;
    rand_cells = 0;
    phases = 0;

    // Default step pattern on a 3x3 matrix: origin pass-through, cost extremes.
    queue_reg(CFG_ROW_COUNT, 64'd3);
    queue_reg(CFG_COL_COUNT, 64'd3);
    queue_cell(16'hFFFF); queue_cell(16'h0000); queue_cell(16'h0001);
    queue_cell(16'hFFFF); queue_cell(16'hFFFF); queue_cell(16'h0000);
    queue_cell(16'h8000); queue_cell(16'h7FFF); queue_cell(16'hFFFF);

    // Diagonal step only, full-scale weight: edge cells have no usable step
    // (saturate, step repeats), later cells sum into saturation.
    fill_pct = 20;
    queue_reg(CFG_NUM_STEPS, 64'd1);
    queue_reg(CFG_STEP_OFFSETS, 64'h0005);
    queue_reg(CFG_STEP_WEIGHTS, 64'h0000_0000_0000_FFFF);
    queue_reg(CFG_ROW_COUNT, 64'd2);
    queue_reg(CFG_COL_COUNT, 64'd3);
    queue_cell(16'hFFFF); queue_cell(16'h1234); queue_cell(16'h0000);
    queue_cell(16'hFFFF); queue_cell(16'h0001); queue_cell(16'hFFFF);

    // Step count above range, a zero-offset step, the largest offset, a zero
    // weight, and a zero-width band so off-diagonal cells fall outside.
    queue_reg(CFG_NUM_STEPS, 64'd7);
    queue_reg(CFG_STEP_OFFSETS, 64'h15F0);
    queue_reg(CFG_STEP_WEIGHTS, 64'h0000_1000_FFFF_8000);
    queue_reg(CFG_WINDOW_ENABLE, 64'd1);
    queue_reg(CFG_WINDOW_SIZE, 64'd0);
    queue_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_reg(CFG_ROW_COUNT, 64'd3);
    queue_reg(CFG_COL_COUNT, 64'd3);
    queue_cell(16'h0400); queue_cell(16'hFFFF); queue_cell(16'h0000);
    queue_cell(16'h0001); queue_cell(16'hFFFF); queue_cell(16'h00FF);
    queue_cell(16'hFFFF); queue_cell(16'h0000); queue_cell(16'hFFFF);

    // Sizes shrink in the middle of a 6x6 matrix: only cells already written
    // are read, and the matrix closes at the end of the current column.
    fill_pct = 30;
    queue_reg(CFG_NUM_STEPS, 64'd4);
    queue_reg(CFG_STEP_OFFSETS, {48'd0, 16'($urandom)});
    queue_reg(CFG_WINDOW_SIZE, 64'd2);
    queue_reg(CFG_ROW_COUNT, 64'd6);
    queue_reg(CFG_COL_COUNT, 64'd6);
    repeat (14) queue_cell(pick_cost());
    queue_reg(CFG_ROW_COUNT, 64'd3);
    queue_reg(CFG_COL_COUNT, 64'd2);
    queue_cell(pick_cost());

    // Oversized row count and zero column count on a single column; the row
    // count then drops so the column closes early.
    fill_pct = 5;
    queue_reg(CFG_WINDOW_ENABLE, 64'd0);
    queue_reg(CFG_ROW_COUNT, 64'd2047);
    queue_reg(CFG_COL_COUNT, 64'd0);
    repeat (12) queue_cell(pick_cost());
    queue_reg(CFG_ROW_COUNT, 64'd13);
    queue_cell(pick_cost());

    // Random settings, each with a few whole matrices of random costs.
    while (rand_cells < RAND_CELLS) begin
      case ($urandom_range(3))
        0: fill_pct = 0;
        1: fill_pct = 10;
        2: fill_pct = 30;
        default: fill_pct = 60;
      endcase
      queue_random_setting();
      repeat ($urandom_range(3, 1)) queue_matrix(rand_cells);
      phases++;
    end

    // Closing stretch with both sides running flat out.
    fill_pct = 0;
    queue_reg(CFG_ROW_COUNT, 64'd4);
    queue_reg(CFG_COL_COUNT, 64'd4);
    queue_matrix(rand_cells);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_tvalid || cfg_valid || expect_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expect_q.size() != 0) begin
      err_cnt++;
      $display("%0d predicted results never arrived", expect_q.size());
    end

    $display("cells %0d, register writes %0d, results checked %0d, mismatches %0d",
             cells_sent, regs_written, results_seen, err_cnt);
    $display("random settings %0d, incl. band limits, clamped sizes, mid-matrix shrink",
             phases);
    if (err_cnt == 0) begin
      $display("[dtw_windowed_cost_accumulator] OK");
    end else begin
      $display("[dtw_windowed_cost_accumulator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/wca_pkg.sv
hw/rtl/wca_history.sv
hw/rtl/dtw_windowed_cost_accumulator.sv
tb/sv/dtw_windowed_cost_accumulator_tb.sv
